>>> rtl/bdcs_pkg.sv
`timescale 1ns / 1ps
package bdcs_pkg;

  // Store dimensions
  localparam int MAX_ELEMS       = 4096;
  localparam int MAX_BLOCKS      = 64;
  localparam int DIGIT_POSITIONS = 10;
  localparam int NZ_DIGITS       = 9;
  localparam int HIST_DEPTH      = MAX_BLOCKS * DIGIT_POSITIONS * NZ_DIGITS;

  localparam int IDX_W   = 13;
  localparam int ELEM_AW = $clog2(MAX_ELEMS);
  localparam int BLK_W   = $clog2(MAX_BLOCKS);
  localparam int HIST_AW = $clog2(HIST_DEPTH);
  localparam int VAL_W   = 31;
  localparam int CNT_W   = 13;
  localparam int DIG_W   = 4;
  localparam int STAT_W  = 2;

  // Reciprocal of ten, used as (v * RECIP10) >> RECIP_SH for v below 2^32
  localparam logic [31:0] RECIP10  = 32'hCCCC_CCCD;
  localparam int          RECIP_SH = 35;

  localparam logic [IDX_W-1:0] LEN_RESET = 13'd4096;
  localparam logic [IDX_W-1:0] BS_RESET  = 13'd64;

  // Action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_LAYOUT = 2'd2;

  // Register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_ARRAY_LENGTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 4'd1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_ERD, S_EDATA, S_DIVA, S_DIVB, S_QCMP,
    S_ARD, S_AWR, S_EWR, S_HRD, S_HDATA, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    M_QUERY, M_OLD, M_NEW, M_REBUILD
  } mode_t;

  // Histogram entry of (block, digit position, digit-1)
  function automatic logic [HIST_AW-1:0] hist_addr(input logic [BLK_W-1:0] blk,
                                                   input logic [DIG_W-1:0] pos,
                                                   input logic [DIG_W-1:0] dig);
    logic [HIST_AW-1:0] a;
    a = HIST_AW'(blk) * HIST_AW'(DIGIT_POSITIONS * NZ_DIGITS)
      + HIST_AW'(pos) * HIST_AW'(NZ_DIGITS) + HIST_AW'(dig);
    return a;
  endfunction

endpackage

>>> rtl/bdcs_ram.sv
`timescale 1ns / 1ps
module bdcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/block_digit_count_store.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake          Contents
// in_      slave      in_tvalid/tready   tdata: left, right, value, digit_position,
//                                        digit_value; tuser: action
// out_     master     out_tvalid/tready  tdata: match_count, status
// cfg_     slave      cfg_valid/ready    cfg_index, cfg_data (array_length, block_size)
//
// One item at a time. Element values and histograms live in two single-port-read RAMs;
// digits come from a divide-by-ten step, the quotient in S_DIVA and the digit in S_DIVB.
// A write swaps the old value's digits for the new one's in the histograms and stores
// the value; a query sums histograms of full blocks (nine entries when digit_value is
// zero) and scans edge-block elements. After reset both RAMs are cleared, during which
// no item is accepted. A register write clears the histograms again and rebuilds them
// for a valid nonempty layout. A held result does not block acceptance of an item.
module block_digit_count_store (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [12:0] left, [25:13] right, [56:26] value, [60:57] digit_position,
  // [64:61] digit_value, [71:65] zero
  input  logic [71:0] in_tdata,
  // [0] action
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [12:0] match_count, [14:13] status, [15] zero
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [bdcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdcs_pkg::IDX_W-1:0]     cfg_data
);
  import bdcs_pkg::*;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;

  logic [IDX_W-1:0]  len_cfg_r, bs_r;
  logic [IDX_W-1:0]  left_r, left_nxt, right_r, right_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [DIG_W-1:0]  dpos_r, dpos_nxt, dval_r, dval_nxt;
  logic              act_r, act_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [STAT_W-1:0] st_r, st_nxt;
  logic [IDX_W-1:0]  blk_r, blk_nxt, bend_r, bend_nxt, p_r, p_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt, end_r, end_nxt, off_r, off_nxt;
  logic [IDX_W-1:0]  seg2s_r, seg2s_nxt, seg2e_r, seg2e_nxt;
  logic              seg2_r, seg2_nxt, div_sel_r, div_sel_nxt;
  logic [DIG_W-1:0]  j_r, j_nxt, k_r, k_nxt;
  logic [VAL_W-1:0]  dv_r, dv_nxt;
  logic [28:0]       q_r, q_nxt;
  logic [DIG_W-1:0]  digs_r [DIGIT_POSITIONS];
  logic [DIG_W-1:0]  digs_nxt [DIGIT_POSITIONS];
  logic [DIG_W-1:0]  sel_r, sel_nxt;
  logic [IDX_W-1:0]  div_rem_r, div_rem_nxt, div_quo_r, div_quo_nxt;
  logic [DIG_W-1:0]  div_cnt_r, div_cnt_nxt;
  logic [HIST_AW-1:0] clr_r, clr_nxt;
  logic              clr_elem_r, scan_req_r, scan_req_nxt;
  logic              out_valid_r;
  logic [15:0]       out_data_r;

  // RAM ports
  logic               elem_we, hist_we;
  logic [ELEM_AW-1:0] elem_waddr, elem_raddr;
  logic [VAL_W-1:0]   elem_wdata, elem_rdata;
  logic [HIST_AW-1:0] hist_waddr, hist_raddr;
  logic [CNT_W-1:0]   hist_wdata, hist_rdata;

  logic [IDX_W-1:0]  len;
  logic              layout_ok, in_acc, cfg_hit;
  logic [IDX_W-1:0]  in_left, in_right;
  logic [DIG_W-1:0]  in_dpos, in_dval;
  logic [13:0]       div_trial;
  logic [IDX_W-1:0]  rem_n, quo_n;
  logic [63:0]       prod;
  logic [VAL_W-1:0]  q_ext, q_ten;
  logic [DIG_W-1:0]  dig_now, start_j;
  logic [CNT_W-1:0]  start_add;
  logic [HIST_AW-1:0] acc_addr;

  bdcs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ELEMS)) u_elem_ram (
    .clk(clk), .we(elem_we), .waddr(elem_waddr), .wdata(elem_wdata),
    .raddr(elem_raddr), .rdata(elem_rdata)
  );

  bdcs_ram #(.WIDTH(CNT_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
    .clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
    .raddr(hist_raddr), .rdata(hist_rdata)
  );

  // Layout checks
  assign len       = (len_cfg_r > IDX_W'(MAX_ELEMS)) ? IDX_W'(MAX_ELEMS) : len_cfg_r;
  assign layout_ok = (bs_r != '0) &&
                     ((IDX_W + BLK_W)'(len) <= {bs_r, BLK_W'(0)});

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && ((cfg_index == REG_ARRAY_LENGTH) ||
                                   (cfg_index == REG_BLOCK_SIZE));
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign in_left  = in_tdata[12:0];
  assign in_right = in_tdata[25:13];
  assign in_dpos  = in_tdata[60:57];
  assign in_dval  = in_tdata[64:61];

  // Restoring divider step
  assign div_trial = {div_rem_r, div_quo_r[IDX_W-1]};
  always_comb begin
    if (div_trial >= {1'b0, bs_r}) begin
      rem_n = IDX_W'(div_trial - {1'b0, bs_r});
      quo_n = {div_quo_r[IDX_W-2:0], 1'b1};
    end else begin
      rem_n = div_trial[IDX_W-1:0];
      quo_n = {div_quo_r[IDX_W-2:0], 1'b0};
    end
  end

  // Divide by ten: quotient registered, then remainder
  assign prod    = 64'({1'b0, dv_r}) * 64'(RECIP10);
  assign q_ext   = VAL_W'(q_r);
  assign q_ten   = (q_ext << 3) + (q_ext << 1);
  assign dig_now = DIG_W'(dv_r - q_ten);

  // First histogram entry of a full block
  assign start_j   = (dval_r == '0) ? '0 : dval_r - 1'b1;
  assign start_add = (dval_r == '0) ? bs_r : '0;

  assign acc_addr = hist_addr(blk_r[BLK_W-1:0], k_r, digs_r[0] - 1'b1);

  // RAM access per state
  always_comb begin
    elem_we    = 1'b0;
    elem_waddr = i_r[ELEM_AW-1:0];
    elem_wdata = val_r;
    elem_raddr = i_r[ELEM_AW-1:0];
    hist_we    = 1'b0;
    hist_waddr = acc_addr;
    hist_wdata = (mode_r == M_OLD) ? hist_rdata - 1'b1 : hist_rdata + 1'b1;
    hist_raddr = acc_addr;
    case (state_r)
      S_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_r;
        hist_wdata = '0;
        elem_we    = clr_elem_r && (clr_r < HIST_AW'(MAX_ELEMS));
        elem_waddr = clr_r[ELEM_AW-1:0];
        elem_wdata = '0;
      end
      S_AWR: hist_we = 1'b1;
      S_EWR: elem_we = 1'b1;
      S_HRD: hist_raddr = hist_addr(blk_r[BLK_W-1:0], dpos_r - 1'b1, j_r);
      default: ;
    endcase
  end

  // Control sequencer
  always_comb begin
    state_nxt = state_r;   mode_nxt = mode_r;
    left_nxt = left_r;     right_nxt = right_r;  val_nxt = val_r;
    dpos_nxt = dpos_r;     dval_nxt = dval_r;    act_nxt = act_r;
    cnt_nxt = cnt_r;       st_nxt = st_r;
    blk_nxt = blk_r;       bend_nxt = bend_r;    p_nxt = p_r;
    i_nxt = i_r;           end_nxt = end_r;      off_nxt = off_r;
    seg2s_nxt = seg2s_r;   seg2e_nxt = seg2e_r;  seg2_nxt = seg2_r;
    div_sel_nxt = div_sel_r;
    j_nxt = j_r;           k_nxt = k_r;
    dv_nxt = dv_r;         q_nxt = q_r;          sel_nxt = sel_r;
    digs_nxt = digs_r;
    div_rem_nxt = div_rem_r; div_quo_nxt = div_quo_r; div_cnt_nxt = div_cnt_r;
    clr_nxt = clr_r;       scan_req_nxt = scan_req_r;

    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == HIST_AW'(HIST_DEPTH - 1)) begin
          scan_req_nxt = 1'b0;
          if (scan_req_r && layout_ok && (len != '0)) begin
            mode_nxt  = M_REBUILD;
            i_nxt     = '0;
            blk_nxt   = '0;
            off_nxt   = '0;
            state_nxt = S_ERD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          left_nxt  = in_left;
          right_nxt = in_right;
          val_nxt   = in_tdata[56:26];
          dpos_nxt  = in_dpos;
          dval_nxt  = in_dval;
          act_nxt   = in_tuser;
          cnt_nxt   = '0;
          st_nxt    = ST_OK;
          div_rem_nxt = '0;
          div_quo_nxt = in_left - 1'b1;
          div_cnt_nxt = '0;
          div_sel_nxt = 1'b0;
          if (!layout_ok) begin
            st_nxt    = ST_BAD_LAYOUT;
            state_nxt = S_DONE;
          end else if (in_tuser == ACT_WRITE) begin
            if ((in_left == '0) || (in_left > len)) begin
              st_nxt    = ST_BAD_INDEX;
              state_nxt = S_DONE;
            end else begin
              mode_nxt  = M_OLD;
              state_nxt = S_DIV;
            end
          end else if ((in_left == '0) || (in_right > len) || (in_left > in_right) ||
                       (in_dpos == '0) || (in_dpos > DIG_W'(DIGIT_POSITIONS)) ||
                       (in_dval > DIG_W'(9))) begin
            st_nxt    = ST_BAD_INDEX;
            state_nxt = S_DONE;
          end else begin
            mode_nxt  = M_QUERY;
            state_nxt = S_DIV;
          end
        end
      end

      S_DIV: begin
        div_rem_nxt = rem_n;
        div_quo_nxt = quo_n;
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DIG_W'(IDX_W - 1)) begin
          if (mode_r == M_OLD) begin
            blk_nxt   = quo_n;
            i_nxt     = left_r - 1'b1;
            state_nxt = S_ERD;
          end else if (!div_sel_r) begin
            // left edge block and its last element
            p_nxt       = quo_n;
            end_nxt     = left_r - 1'b1 + bs_r - 1'b1 - rem_n;
            div_sel_nxt = 1'b1;
            div_rem_nxt = '0;
            div_quo_nxt = right_r - 1'b1;
            div_cnt_nxt = '0;
          end else begin
            i_nxt = left_r - 1'b1;
            if (p_r == quo_n) begin
              end_nxt   = right_r - 1'b1;
              seg2_nxt  = 1'b0;
              state_nxt = S_ERD;
            end else begin
              seg2s_nxt = right_r - 1'b1 - rem_n;
              seg2e_nxt = right_r - 1'b1;
              seg2_nxt  = 1'b1;
              if (p_r + 1'b1 < quo_n) begin
                blk_nxt   = p_r + 1'b1;
                bend_nxt  = quo_n - 1'b1;
                j_nxt     = start_j;
                cnt_nxt   = cnt_r + start_add;
                state_nxt = S_HRD;
              end else begin
                state_nxt = S_ERD;
              end
            end
          end
        end
      end

      // Full-block histogram sums
      S_HRD: state_nxt = S_HDATA;

      S_HDATA: begin
        cnt_nxt = (dval_r == '0) ? cnt_r - hist_rdata : cnt_r + hist_rdata;
        if ((dval_r == '0) && (j_r != DIG_W'(NZ_DIGITS - 1))) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_HRD;
        end else if (blk_r == bend_r) begin
          state_nxt = S_ERD;
        end else begin
          blk_nxt   = blk_r + 1'b1;
          j_nxt     = start_j;
          cnt_nxt   = ((dval_r == '0) ? cnt_r - hist_rdata : cnt_r + hist_rdata)
                      + start_add;
          state_nxt = S_HRD;
        end
      end

      // Element fetch and digit split
      S_ERD: state_nxt = S_EDATA;

      S_EDATA: begin
        dv_nxt    = elem_rdata;
        k_nxt     = '0;
        state_nxt = S_DIVA;
      end

      S_DIVA: begin
        q_nxt     = prod[RECIP_SH +: 29];
        state_nxt = S_DIVB;
      end

      S_DIVB: begin
        for (int n = 0; n < DIGIT_POSITIONS - 1; n++) begin
          digs_nxt[n] = digs_r[n+1];
        end
        digs_nxt[DIGIT_POSITIONS-1] = dig_now;
        if (k_r == dpos_r - 1'b1) begin
          sel_nxt = dig_now;
        end
        dv_nxt = q_ext;
        k_nxt  = k_r + 1'b1;
        state_nxt = S_DIVA;
        if (k_r == DIG_W'(DIGIT_POSITIONS - 1)) begin
          k_nxt     = '0;
          state_nxt = (mode_r == M_QUERY) ? S_QCMP : S_ARD;
        end
      end

      S_QCMP: begin
        if (sel_r == dval_r) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (i_r != end_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_ERD;
        end else if (seg2_r) begin
          i_nxt     = seg2s_r;
          end_nxt   = seg2e_r;
          seg2_nxt  = 1'b0;
          state_nxt = S_ERD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // Histogram update, one digit position per pass
      S_ARD, S_AWR: begin
        if ((state_r == S_ARD) && (digs_r[0] != '0)) begin
          state_nxt = S_AWR;
        end else begin
          state_nxt = S_ARD;
          for (int n = 0; n < DIGIT_POSITIONS - 1; n++) begin
            digs_nxt[n] = digs_r[n+1];
          end
          digs_nxt[DIGIT_POSITIONS-1] = '0;
          k_nxt = k_r + 1'b1;
          if (k_r == DIG_W'(DIGIT_POSITIONS - 1)) begin
            k_nxt = '0;
            case (mode_r)
              M_OLD: begin
                mode_nxt  = M_NEW;
                dv_nxt    = val_r;
                state_nxt = S_DIVA;
              end
              M_NEW: state_nxt = S_EWR;
              default: begin
                if (i_r == len - 1'b1) begin
                  state_nxt = S_IDLE;
                end else begin
                  i_nxt = i_r + 1'b1;
                  if (off_r == bs_r - 1'b1) begin
                    off_nxt = '0;
                    blk_nxt = blk_r + 1'b1;
                  end else begin
                    off_nxt = off_r + 1'b1;
                  end
                  state_nxt = S_ERD;
                end
              end
            endcase
          end
        end
      end

      S_EWR: state_nxt = S_DONE;

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // A register write restarts the clear and rebuild
    if (cfg_hit) begin
      state_nxt    = S_CLEAR;
      clr_nxt      = '0;
      scan_req_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      mode_r      <= M_QUERY;
      clr_r       <= '0;
      clr_elem_r  <= 1'b1;
      scan_req_r  <= 1'b0;
      len_cfg_r   <= LEN_RESET;
      bs_r        <= BS_RESET;
      out_valid_r <= 1'b0;
      div_sel_r   <= 1'b0;
      seg2_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      mode_r     <= mode_nxt;
      clr_r      <= clr_nxt;
      scan_req_r <= scan_req_nxt;
      div_sel_r  <= div_sel_nxt;
      seg2_r     <= seg2_nxt;
      if ((state_r == S_CLEAR) && (clr_r == HIST_AW'(HIST_DEPTH - 1))) begin
        clr_elem_r <= 1'b0;
      end
      if (cfg_valid && (cfg_index == REG_ARRAY_LENGTH)) begin
        len_cfg_r <= cfg_data;
      end
      if (cfg_valid && (cfg_index == REG_BLOCK_SIZE)) begin
        bs_r <= cfg_data;
      end
      if ((state_r == S_DONE) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    left_r <= left_nxt;   right_r <= right_nxt; val_r <= val_nxt;
    dpos_r <= dpos_nxt;   dval_r <= dval_nxt;   act_r <= act_nxt;
    cnt_r <= cnt_nxt;     st_r <= st_nxt;
    blk_r <= blk_nxt;     bend_r <= bend_nxt;   p_r <= p_nxt;
    i_r <= i_nxt;         end_r <= end_nxt;     off_r <= off_nxt;
    seg2s_r <= seg2s_nxt; seg2e_r <= seg2e_nxt;
    j_r <= j_nxt;         k_r <= k_nxt;
    dv_r <= dv_nxt;       q_r <= q_nxt;         sel_r <= sel_nxt;
    digs_r <= digs_nxt;
    div_rem_r <= div_rem_nxt; div_quo_r <= div_quo_nxt; div_cnt_r <= div_cnt_nxt;
    if ((state_r == S_DONE) && (!out_valid_r || out_tready)) begin
      // writes always report a zero count
      out_data_r <= {1'b0, st_r, (act_r == ACT_WRITE) ? CNT_W'(0) : cnt_r};
    end
  end

  // Checks
  a_acc_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !cfg_hit |=> state_r != S_IDLE)
    else $error("accepted item did not start work");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_tready)
    else $error("item accepted during clear");

  a_rmw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_AWR |-> hist_waddr == $past(hist_raddr))
    else $error("histogram write-back to a different entry");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> div_cnt_r < DIG_W'(IDX_W))
    else $error("divider ran past its width");

endmodule

>>> tb/sv/bdcs_checker.sv
`timescale 1ns / 1ps
module bdcs_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [bdcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdcs_pkg::IDX_W-1:0]     cfg_data,
  output int          fail_count,
  output int          pending
);
  import bdcs_pkg::*;

  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [STAT_W-1:0] st;
  } tally_t;

  // shadow copy of the store and its layout registers
  logic [VAL_W-1:0] elem_mem [MAX_ELEMS];
  int unsigned      arr_len;
  int unsigned      blk_size;
  tally_t           awaited_tallies [$];

  // decimal digit p (0 = units) of v
  function automatic int unsigned decimal_digit(logic [VAL_W-1:0] v, int unsigned p);
    longint unsigned x;
    x = v;
    repeat (p) x = x / 10;
    return int'(x % 10);
  endfunction

  // work out the result of one item and apply any write to the shadow store
  function automatic tally_t tally_item(logic act, int unsigned lft, int unsigned rgt,
                                        logic [VAL_W-1:0] val, int unsigned dpos,
                                        int unsigned dval);
    tally_t      t;
    int unsigned len;
    int unsigned n;
    len = (arr_len > MAX_ELEMS) ? MAX_ELEMS : arr_len;
    t.cnt = '0;
    t.st  = ST_OK;
    n = 0;
    if (blk_size == 0 || (len + blk_size - 1) / blk_size > MAX_BLOCKS) begin
      t.st = ST_BAD_LAYOUT;
    end else if (act == ACT_WRITE) begin
      if (lft < 1 || lft > len) t.st = ST_BAD_INDEX;
      else elem_mem[lft-1] = val;
    end else if (lft < 1 || rgt > len || lft > rgt || dpos < 1 ||
                 dpos > DIGIT_POSITIONS || dval > 9) begin
      t.st = ST_BAD_INDEX;
    end else begin
      // full blocks hold exactly the elements in range, so a plain scan agrees
      for (int unsigned i = lft - 1; i < rgt; i++)
        if (decimal_digit(elem_mem[i], dpos - 1) == dval) n++;
      t.cnt = n[CNT_W-1:0];
    end
    return t;
  endfunction

  always @(posedge clk) begin
    tally_t exp_t;
    tally_t got_t;
    if (!rst_n) begin
      foreach (elem_mem[i]) elem_mem[i] = '0;
      arr_len    = LEN_RESET;
      blk_size   = BS_RESET;
      fail_count = 0;
      awaited_tallies.delete();
    end else begin
      // result side first: it always belongs to an older item
      if (out_tvalid && out_tready) begin
        got_t.cnt = out_tdata[12:0];
        got_t.st  = out_tdata[14:13];
        if (awaited_tallies.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected item count=%0d status=%0d", $time, got_t.cnt,
                   got_t.st);
        end else begin
          exp_t = awaited_tallies.pop_front();
          if (exp_t.cnt !== got_t.cnt || exp_t.st !== got_t.st) begin
            fail_count++;
            $display("%0t: mismatch count exp %0d got %0d, status exp %0d got %0d",
                     $time, exp_t.cnt, got_t.cnt, exp_t.st, got_t.st);
          end
        end
      end
      // register writes; unknown indexes change nothing
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ARRAY_LENGTH) arr_len = cfg_data;
        else if (cfg_index == REG_BLOCK_SIZE) blk_size = cfg_data;
      end
      if (in_tvalid && in_tready)
        awaited_tallies.push_back(tally_item(in_tuser, in_tdata[12:0], in_tdata[25:13],
                                             in_tdata[56:26], in_tdata[60:57],
                                             in_tdata[64:61]));
    end
    pending = awaited_tallies.size();
  end

endmodule

>>> tb/sv/tb_block_digit_count_store.sv
`timescale 1ns / 1ps
module tb_block_digit_count_store;
  import bdcs_pkg::*;

  localparam int IDLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [IDX_W-1:0]     cfg_data = '0;
  int          fails;
  int          pend;
  int          items_sent = 0;

  always #5 clk = ~clk;

  block_digit_count_store i_dut (.*);

  bdcs_checker i_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data, .fail_count(fails), .pending(pend)
  );

  // offer one item after a random gap, or none in some stretches; tvalid stays high after the handshake
  task automatic offer_item(logic act, int unsigned lft, int unsigned rgt,
                            logic [VAL_W-1:0] val, int unsigned dpos, int unsigned dval);
    int n;
    n = ((items_sent / 45) % 4 == 1) ? 0 : $urandom_range(0, 18);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {7'd0, 4'(dval), 4'(dpos), val, 13'(rgt), 13'(lft)};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    items_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pend != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [IDX_W-1:0] dat);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= dat;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  // random item for the current layout: mostly well-formed, some noise
  task automatic random_item(int unsigned len, int unsigned bs);
    int unsigned kind, lim, lft, rgt, span;
    logic [VAL_W-1:0] val;
    logic act;
    kind = $urandom_range(0, 19);
    act  = $urandom_range(0, 1);
    lim  = (len == 0) ? 50 : ((len > MAX_ELEMS) ? MAX_ELEMS : len);
    case ($urandom_range(0, 3))
      0:       val = $urandom_range(0, 999);
      1:       val = 31'(64'd10 ** $urandom_range(0, 9)) - 31'($urandom_range(0, 1));
      default: val = 31'($urandom);
    endcase
    if (kind == 0) begin
      offer_item(act, $urandom_range(0, 8191), $urandom_range(0, 8191), val,
                 $urandom_range(0, 15), $urandom_range(0, 15));
    end else if (act == ACT_WRITE) begin
      lft = (kind == 1) ? ($urandom_range(0, 1) ? 0 : $urandom_range(lim + 1, 8191))
                        : $urandom_range(1, lim);
      offer_item(ACT_WRITE, lft, $urandom_range(0, 8191), val, $urandom_range(0, 15),
                 $urandom_range(0, 15));
    end else begin
      lft  = $urandom_range(1, lim);
      span = (lim > 200) ? $urandom_range(0, 2 * bs) : $urandom_range(0, lim);
      rgt  = (lft + span > lim) ? lim : lft + span;
      if (kind == 1) offer_item(ACT_QUERY, rgt, lft, val, $urandom_range(0, 15),
                                $urandom_range(0, 15));
      else offer_item(ACT_QUERY, lft, rgt, val, $urandom_range(1, 10),
                      $urandom_range(0, 9));
    end
  endtask

  // result side: random stalls, stretches without, one long hold-off
  initial begin
    int n, seen;
    seen = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (seen == 300) begin
        out_tready <= 1'b0;
        repeat (4000) @(posedge clk);
      end
      n = ((seen / 50) % 4 == 0) ? 0 : $urandom_range(0, 18);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      seen++;
    end
  end

  // watchdog on cycles with no handshake anywhere
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default layout: 4096 elements in blocks of 64
    offer_item(ACT_WRITE, 1, 0, 31'h7FFF_FFFF, 0, 0);
    offer_item(ACT_WRITE, 4096, 8191, 31'd1234567890, 15, 15);
    offer_item(ACT_WRITE, 65, 0, 31'd9, 1, 0);
    offer_item(ACT_WRITE, 128, 0, 31'd1000000000, 1, 0);
    offer_item(ACT_WRITE, 0, 5, 31'd7, 1, 0);
    offer_item(ACT_WRITE, 4097, 5, 31'd7, 1, 0);
    offer_item(ACT_WRITE, 8191, 5, 31'd7, 1, 0);
    offer_item(ACT_QUERY, 1, 4096, 0, 1, 0);
    offer_item(ACT_QUERY, 1, 4096, 0, 3, 5);
    offer_item(ACT_QUERY, 1, 1, 0, 10, 2);
    offer_item(ACT_QUERY, 4096, 4096, 0, 10, 1);
    offer_item(ACT_QUERY, 64, 65, 0, 1, 9);
    offer_item(ACT_QUERY, 65, 128, 0, 10, 1);
    offer_item(ACT_QUERY, 2, 200, 0, 10, 0);
    offer_item(ACT_QUERY, 0, 10, 0, 1, 0);
    offer_item(ACT_QUERY, 1, 4097, 0, 1, 0);
    offer_item(ACT_QUERY, 1, 8191, 0, 1, 0);
    offer_item(ACT_QUERY, 10, 9, 0, 1, 0);
    offer_item(ACT_QUERY, 1, 10, 0, 0, 0);
    offer_item(ACT_QUERY, 1, 10, 0, 11, 0);
    offer_item(ACT_QUERY, 1, 10, 0, 15, 0);
    offer_item(ACT_QUERY, 1, 10, 0, 1, 10);
    offer_item(ACT_QUERY, 1, 10, 0, 1, 15);
    repeat (80) random_item(4096, 64);

    // small array, moderate blocks; sender pause mid-phase
    write_reg(REG_ARRAY_LENGTH, 13'd100);
    write_reg(REG_BLOCK_SIZE, 13'd10);
    write_reg(REG_UNUSED, 13'd5);
    repeat (300) random_item(100, 10);
    wait_drained();
    repeat (300) random_item(100, 10);

    // one element per block, the most blocks allowed
    write_reg(REG_ARRAY_LENGTH, 13'd64);
    write_reg(REG_BLOCK_SIZE, 13'd1);
    repeat (200) random_item(64, 1);

    // block size equal to the store size, a single partial block
    write_reg(REG_BLOCK_SIZE, 13'd4096);
    write_reg(REG_ARRAY_LENGTH, 13'd20);
    repeat (150) random_item(20, 4096);

    // empty array: every index bad
    write_reg(REG_ARRAY_LENGTH, 13'd0);
    write_reg(REG_BLOCK_SIZE, 13'd7);
    repeat (40) random_item(0, 7);

    // zero block size: layout invalid
    write_reg(REG_ARRAY_LENGTH, 13'd300);
    write_reg(REG_BLOCK_SIZE, 13'd0);
    repeat (40) random_item(300, 1);

    // length past the store, too many blocks
    write_reg(REG_ARRAY_LENGTH, 13'd8191);
    write_reg(REG_BLOCK_SIZE, 13'd2);
    repeat (40) random_item(4096, 2);

    wait_drained();
    repeat (60) @(posedge clk);
    if (fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
